/* hdl/thb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thb_pkg
// Shared types and constants for the tagged hash bucket unit.
// ----------------------------------------------------------------------------
package thb_pkg;

   localparam int CMD_W      = 2;
   localparam int SLOT_W     = 3;
   localparam int TAG_W      = 7;
   localparam int HASH_IN_W  = 64;
   localparam int VALUE_IN_W = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 4;

   localparam logic [COUNT_W-1:0] NONE_SLOT = 4'd8;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_FIND   = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_BAD_SLOT  = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

endpackage

/* hdl/tagged_hash_bucket_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_hash_bucket_unit
// Eight-way bucket of tagged entries with insert, remove, find and clear.
//
// A request beat on req_* carries a command, slot, tag, full hash and value.
// Each request gives exactly one response beat on rsp_*: status, found slot,
// entry count and been-full flag after the command, and the found value.
// The request is registered on acceptance; in execute the tag and hash are
// compared against every slot in parallel, and the store update and the
// response register load follow once the response register is free. A new
// request is not taken until the current one has left execute; req_stall is
// high while in execute. If the response register still holds an untaken
// beat, the unit waits in execute until rsp_stall drops.
// Reset empties the bucket (count and been-full cleared) and drops rsp_valid;
// slot contents are not cleared since slots at or beyond the count are never
// read.
// ----------------------------------------------------------------------------
module tagged_hash_bucket_unit #(
   parameter int ENTRIES     = 8,
   parameter int HASH_WIDTH  = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [thb_pkg::CMD_W-1:0]         req_command,
   input  logic [thb_pkg::SLOT_W-1:0]        req_slot_index,
   input  logic [thb_pkg::TAG_W-1:0]         req_tag,
   input  logic [thb_pkg::HASH_IN_W-1:0]     req_full_hash,
   input  logic [thb_pkg::VALUE_IN_W-1:0]    req_value_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [thb_pkg::STATUS_W-1:0]      rsp_status,
   output logic [thb_pkg::COUNT_W-1:0]       rsp_found_slot,
   output logic [thb_pkg::COUNT_W-1:0]       rsp_entry_count,
   output logic                              rsp_been_full,
   output logic [thb_pkg::VALUE_IN_W-1:0]    rsp_value_out
);
   import thb_pkg::*;

   ctrl_cmd_type cmd;

   thb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   thb_datapath #(
      .ENTRIES     (ENTRIES),
      .HASH_WIDTH  (HASH_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_command     (req_command),
      .req_slot_index  (req_slot_index),
      .req_tag         (req_tag),
      .req_full_hash   (req_full_hash),
      .req_value_word  (req_value_word),
      .rsp_status      (rsp_status),
      .rsp_found_slot  (rsp_found_slot),
      .rsp_entry_count (rsp_entry_count),
      .rsp_been_full   (rsp_been_full),
      .rsp_value_out   (rsp_value_out)
   );

endmodule

/* hdl/thb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thb_ctrl
// Sequencer: takes a request beat, runs the execute state, and leaves it to
// hand the response to the output register once that register is free.
// ----------------------------------------------------------------------------
module thb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output thb_pkg::ctrl_cmd_type cmd
);
   import thb_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid;
   assign cmd.commit  = (state_ff == ST_EXEC) && out_free;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/thb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thb_datapath
// Entry store, request capture, per-slot tag and hash compare, update of
// count and been-full flag, and the response register.
// ----------------------------------------------------------------------------
module thb_datapath #(
   parameter int ENTRIES     = 8,
   parameter int HASH_WIDTH  = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  thb_pkg::ctrl_cmd_type             cmd,
   input  logic [thb_pkg::CMD_W-1:0]         req_command,
   input  logic [thb_pkg::SLOT_W-1:0]        req_slot_index,
   input  logic [thb_pkg::TAG_W-1:0]         req_tag,
   input  logic [thb_pkg::HASH_IN_W-1:0]     req_full_hash,
   input  logic [thb_pkg::VALUE_IN_W-1:0]    req_value_word,
   output logic [thb_pkg::STATUS_W-1:0]      rsp_status,
   output logic [thb_pkg::COUNT_W-1:0]       rsp_found_slot,
   output logic [thb_pkg::COUNT_W-1:0]       rsp_entry_count,
   output logic                              rsp_been_full,
   output logic [thb_pkg::VALUE_IN_W-1:0]    rsp_value_out
);
   import thb_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(ENTRIES);

   // entry store
   logic [TAG_W-1:0]       tags_ff   [ENTRIES];
   logic [HASH_WIDTH-1:0]  hashes_ff [ENTRIES];
   logic [VALUE_WIDTH-1:0] values_ff [ENTRIES];

   // captured request
   logic [CMD_W-1:0]       cmd_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic [TAG_W-1:0]       tag_ff;
   logic [HASH_WIDTH-1:0]  hash_ff;
   logic [VALUE_WIDTH-1:0] val_ff;

   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   full_ff, full_in;

   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [COUNT_W-1:0]     found_ff, found_in;
   logic [VALUE_IN_W-1:0]  vout_ff, vout_in;

   logic [ENTRIES-1:0]     match;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_idx;
   logic [IDX_W-1:0]       last_idx;
   logic [TAG_W-1:0]       wr_tag;
   logic [HASH_WIDTH-1:0]  wr_hash;
   logic [VALUE_WIDTH-1:0] wr_val;
   logic [COUNT_W-1:0]     slot_ext;
   logic [COUNT_W-1:0]     count_dec;

   assign slot_ext  = COUNT_W'(slot_ff);
   assign count_dec = count_ff - COUNT_W'(1);
   assign last_idx  = count_dec[IDX_W-1:0];

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = (COUNT_W'(i) < count_ff) && (tags_ff[i] == tag_ff)
                    && (hashes_ff[i] == hash_ff);
      end
   end

   always_comb begin
      count_in  = count_ff;
      full_in   = full_ff;
      status_in = STAT_OK;
      found_in  = NONE_SLOT;
      vout_in   = '0;
      wr_en     = 1'b0;
      wr_idx    = slot_ff[IDX_W-1:0];
      wr_tag    = tag_ff;
      wr_hash   = hash_ff;
      wr_val    = val_ff;
      case (cmd_type'(cmd_ff))
         CMD_INSERT: begin
            if (count_ff >= FULL_COUNT) begin
               status_in = STAT_FULL;
            end else if (slot_ext != count_ff) begin
               status_in = STAT_BAD_SLOT;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + COUNT_W'(1);
               if (count_in >= FULL_COUNT) begin
                  full_in = 1'b1;
               end
            end
         end
         CMD_REMOVE: begin
            if (slot_ext >= count_ff) begin
               status_in = STAT_BAD_SLOT;
            end else begin
               wr_en    = 1'b1;
               wr_tag   = tags_ff[last_idx];
               wr_hash  = hashes_ff[last_idx];
               wr_val   = values_ff[last_idx];
               count_in = count_dec;
            end
         end
         CMD_FIND: begin
            status_in = STAT_NOT_FOUND;
            for (int i = ENTRIES - 1; i >= 0; i--) begin
               if (match[i]) begin
                  status_in = STAT_OK;
                  found_in  = COUNT_W'(i);
                  vout_in   = VALUE_IN_W'(values_ff[i]);
               end
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
            full_in  = 1'b0;
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_command;
         slot_ff <= req_slot_index;
         tag_ff  <= req_tag;
         hash_ff <= HASH_WIDTH'(req_full_hash);
         val_ff  <= VALUE_WIDTH'(req_value_word);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         tags_ff[wr_idx]   <= wr_tag;
         hashes_ff[wr_idx] <= wr_hash;
         values_ff[wr_idx] <= wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         full_ff  <= 1'b0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
         full_ff  <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         vout_ff   <= vout_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_found_slot  = found_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_been_full   = full_ff;
   assign rsp_value_out   = vout_ff;

endmodule
